### src/pmdt_pkg.sv
package pmdt_pkg;

	localparam int unsigned MS_W = 64;
	localparam int unsigned SEC_W = 54;
	localparam int unsigned SEC_TGT_W = SEC_W + 1;
	localparam int unsigned DELAY_W = 16;

	typedef logic [1:0] op_t;
	typedef logic [7:0] byte_t;

	localparam op_t OP_TICK = 2'd0;
	localparam op_t OP_WRITE = 2'd1;
	localparam op_t OP_READ = 2'd2;

	localparam byte_t FIRST_MS_PORT = 8'd24;
	localparam byte_t LAST_MS_PORT = 8'd29;
	localparam byte_t SECONDS_PORT = 8'd30;

endpackage

### src/port_mapped_delay_timers.sv
// channel | signals                               | direction
// --------+---------------------------------------+-------------
// request | in_valid in_ready operation port data | into block
// result  | out_valid out_ready running           | out of block
//
// a request is registered on accept and handled from the input stage; a port read
// gives its result on the following cycle through the output register.
// one request per cycle unless a read is held; the ms timers use a 64-bit add and compare.
// arst_n clears all counters and timers at once.
// a read waits in the input stage while a result is still not taken; ticks and
// writes pass regardless.
module port_mapped_delay_timers #(
	parameter int unsigned MS_TIMER_COUNT = 3,
	parameter int unsigned TICKS_PER_SECOND = 1000
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  pmdt_pkg::op_t       operation,
	input  pmdt_pkg::byte_t     port,
	input  pmdt_pkg::byte_t     data,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                running
);

	localparam int unsigned IdxW = (MS_TIMER_COUNT > 1) ? $clog2(MS_TIMER_COUNT) : 1;
	localparam int unsigned TickW = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;

	logic                          valid_s1;
	pmdt_pkg::op_t                 op_s1;
	pmdt_pkg::byte_t               port_s1;
	pmdt_pkg::byte_t               data_s1;

	logic [pmdt_pkg::MS_W-1:0]     elapsed_ms_q;
	logic [TickW-1:0]              ms_in_second_q;
	logic [pmdt_pkg::SEC_W-1:0]    elapsed_sec_q;
	logic [pmdt_pkg::MS_W-1:0]     ms_target_q [MS_TIMER_COUNT];
	logic [pmdt_pkg::DELAY_W-1:0]  ms_delay_q [MS_TIMER_COUNT];
	logic [pmdt_pkg::SEC_TGT_W-1:0] sec_target_q;
	logic                          out_valid_q;
	logic                          running_q;

	logic                          out_free;
	logic                          adv_s1;
	logic                          is_tick;
	logic                          is_write;
	logic                          is_read;
	pmdt_pkg::byte_t               port_off;
	logic [1:0]                    pair;
	logic                          slot_ok;
	logic [IdxW-1:0]               slot_idx;
	logic                          is_sec_port;
	logic [pmdt_pkg::MS_W-1:0]     sel_target;
	logic [pmdt_pkg::DELAY_W-1:0]  sel_delay;
	logic [pmdt_pkg::DELAY_W-1:0]  new_delay;
	logic [pmdt_pkg::MS_W-1:0]     arm_target;
	logic                          ms_reached;
	logic                          sec_reached;
	logic                          ms_armed;
	logic                          sec_armed;
	logic                          run_next;
	logic                          sec_wrap;

	assign out_free = !out_valid_q || out_ready;
	assign is_tick = (op_s1 == pmdt_pkg::OP_TICK);
	assign is_write = (op_s1 == pmdt_pkg::OP_WRITE);
	assign is_read = (op_s1 == pmdt_pkg::OP_READ);
	assign adv_s1 = valid_s1 && (!is_read || out_free);
	assign in_ready = !valid_s1 || adv_s1;

	assign port_off = port_s1 - pmdt_pkg::FIRST_MS_PORT;
	assign pair = port_off[2:1];
	assign slot_ok = (port_s1 >= pmdt_pkg::FIRST_MS_PORT) && (port_s1 <= pmdt_pkg::LAST_MS_PORT)
		&& (32'(pair) < MS_TIMER_COUNT);
	assign slot_idx = IdxW'(pair);
	assign is_sec_port = (port_s1 == pmdt_pkg::SECONDS_PORT);

	assign sel_target = ms_target_q[slot_idx];
	assign sel_delay = ms_delay_q[slot_idx];
	assign new_delay = port_s1[0] ? {sel_delay[15:8], data_s1} : {data_s1, sel_delay[7:0]};
	assign arm_target = elapsed_ms_q + pmdt_pkg::MS_W'(new_delay);

	assign ms_armed = (sel_target != '0);
	assign ms_reached = (elapsed_ms_q >= sel_target);
	assign sec_armed = (sec_target_q != '0);
	assign sec_reached = ({1'b0, elapsed_sec_q} >= sec_target_q);
	assign sec_wrap = (ms_in_second_q == TickW'(TICKS_PER_SECOND - 1));

	always_comb begin
		run_next = 1'b0;
		if (slot_ok) begin
			run_next = ms_armed && !ms_reached;
		end else if (is_sec_port) begin
			run_next = sec_armed && !sec_reached;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1 <= operation;
			port_s1 <= port;
			data_s1 <= data;
		end
	end

	// time base
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_ms_q <= '0;
			ms_in_second_q <= '0;
			elapsed_sec_q <= '0;
		end else if (adv_s1 && is_tick) begin
			elapsed_ms_q <= elapsed_ms_q + 1'b1;
			if (sec_wrap) begin
				ms_in_second_q <= '0;
				elapsed_sec_q <= elapsed_sec_q + 1'b1;
			end else begin
				ms_in_second_q <= ms_in_second_q + 1'b1;
			end
		end
	end

	// millisecond timers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MS_TIMER_COUNT; i++) begin
				ms_target_q[i] <= '0;
				ms_delay_q[i] <= '0;
			end
		end else if (adv_s1 && slot_ok) begin
			for (int i = 0; i < MS_TIMER_COUNT; i++) begin
				if (slot_idx == IdxW'(i)) begin
					if (is_write) begin
						ms_delay_q[i] <= new_delay;
						if (port_s1[0]) begin
							ms_target_q[i] <= arm_target;
						end
					end else if (is_read && ms_armed && ms_reached) begin
						ms_target_q[i] <= '0;
						ms_delay_q[i] <= '0;
					end
				end
			end
		end
	end

	// seconds timer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_target_q <= '0;
		end else if (adv_s1 && is_sec_port) begin
			if (is_write) begin
				sec_target_q <= {1'b0, elapsed_sec_q} + pmdt_pkg::SEC_TGT_W'(data_s1);
			end else if (is_read && sec_armed && sec_reached) begin
				sec_target_q <= '0;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && is_read) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && is_read) begin
			running_q <= run_next;
		end
	end

	assign out_valid = out_valid_q;
	assign running = running_q;

endmodule

### bench/tb_port_mapped_delay_timers.sv
module tb_port_mapped_delay_timers;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MS_TIMERS = 3;
	localparam int unsigned TICKS_PER_SEC = 1000;
	localparam pmdt_pkg::op_t OP_UNUSED = 2'd3;
	localparam int unsigned RANDOM_ITEMS = 1100;
	localparam int unsigned CALM_AFTER = 950;
	localparam int unsigned STALL_LIMIT = 2000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	pmdt_pkg::op_t operation;
	pmdt_pkg::byte_t port;
	pmdt_pkg::byte_t data;
	logic out_valid;
	logic out_ready;
	logic running;

	port_mapped_delay_timers #(
		.MS_TIMER_COUNT(MS_TIMERS),
		.TICKS_PER_SECOND(TICKS_PER_SEC)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.port(port),
		.data(data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.running(running)
	);

	class timer_scoreboard;
		bit [pmdt_pkg::MS_W-1:0] now_ms;
		bit [9:0] ms_of_second;
		bit [pmdt_pkg::SEC_W-1:0] now_sec;
		bit [pmdt_pkg::MS_W-1:0] ms_expiry[MS_TIMERS];
		bit [pmdt_pkg::DELAY_W-1:0] ms_delay[MS_TIMERS];
		bit [63:0] sec_expiry;
		bit running_due[$];
		int unsigned n_requests;
		int unsigned n_reads;
		int unsigned n_running;
		int unsigned n_expiries;
		int unsigned n_checked;

		function new();
			now_ms = '0;
			ms_of_second = '0;
			now_sec = '0;
			sec_expiry = '0;
			foreach (ms_expiry[i]) begin
				ms_expiry[i] = '0;
				ms_delay[i] = '0;
			end
			n_requests = 0;
			n_reads = 0;
			n_running = 0;
			n_expiries = 0;
			n_checked = 0;
		endfunction

		function int slot_of(pmdt_pkg::byte_t p);
			int k;
			if (p < pmdt_pkg::FIRST_MS_PORT || p > pmdt_pkg::LAST_MS_PORT)
				return -1;
			k = (p - pmdt_pkg::FIRST_MS_PORT) >> 1;
			return (k < MS_TIMERS) ? k : -1;
		endfunction

		function void note_request(pmdt_pkg::op_t op, pmdt_pkg::byte_t p, pmdt_pkg::byte_t d);
			int s;
			bit run;
			s = slot_of(p);
			run = 1'b0;
			n_requests++;
			case (op)
				pmdt_pkg::OP_TICK: begin
					now_ms++;
					if (ms_of_second + 1 >= TICKS_PER_SEC) begin
						ms_of_second = '0;
						now_sec++;
					end else begin
						ms_of_second++;
					end
				end
				pmdt_pkg::OP_WRITE: begin
					if (s >= 0) begin
						if (!p[0]) begin
							ms_delay[s][15:8] = d;
						end else begin
							ms_delay[s][7:0] = d;
							ms_expiry[s] = now_ms + 64'(ms_delay[s]);
						end
					end else if (p == pmdt_pkg::SECONDS_PORT) begin
						sec_expiry = 64'(now_sec) + 64'(d);
					end
				end
				pmdt_pkg::OP_READ: begin
					if (s >= 0) begin
						if (ms_expiry[s] != 0) begin
							if (now_ms >= ms_expiry[s]) begin
								ms_expiry[s] = '0;
								ms_delay[s] = '0;
								n_expiries++;
							end else begin
								run = 1'b1;
							end
						end
					end else if (p == pmdt_pkg::SECONDS_PORT) begin
						if (sec_expiry != 0) begin
							if (64'(now_sec) >= sec_expiry) begin
								sec_expiry = '0;
								n_expiries++;
							end else begin
								run = 1'b1;
							end
						end
					end
					n_reads++;
					if (run)
						n_running++;
					running_due.push_back(run);
				end
				default: ;
			endcase
		endfunction

		function bit check_result(logic got, output string why);
			bit want;
			why = "";
			n_checked++;
			if (running_due.size() == 0) begin
				why = $sformatf("read result %0d: running=%b with no read outstanding",
					n_checked, got);
				return 1'b0;
			end
			want = running_due.pop_front();
			if (got !== want) begin
				why = $sformatf("read result %0d: running=%b, expected %b", n_checked, got, want);
				return 1'b0;
			end
			return 1'b1;
		endfunction
	endclass

	timer_scoreboard sb = new();
	int unsigned n_mismatches = 0;
	int unsigned n_counted = 0;
	bit gaps_on = 1'b1;
	bit calm = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		n_mismatches++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	function automatic pmdt_pkg::byte_t hi_port_of(int unsigned k);
		return pmdt_pkg::byte_t'(pmdt_pkg::FIRST_MS_PORT + 2 * k);
	endfunction

	function automatic pmdt_pkg::byte_t lo_port_of(int unsigned k);
		return pmdt_pkg::byte_t'(pmdt_pkg::FIRST_MS_PORT + 2 * k + 1);
	endfunction

	task automatic send_request(pmdt_pkg::op_t req_op, pmdt_pkg::byte_t req_port,
			pmdt_pkg::byte_t req_data);
		if (gaps_on && !calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= req_op;
		port <= req_port;
		data <= req_data;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		sb.note_request(req_op, req_port, req_data);
		n_counted++;
	endtask

	task automatic tick_ms(int unsigned n);
		repeat (n) send_request(pmdt_pkg::OP_TICK, pmdt_pkg::byte_t'($urandom),
			pmdt_pkg::byte_t'($urandom));
	endtask

	task automatic write_port(pmdt_pkg::byte_t p, pmdt_pkg::byte_t d);
		send_request(pmdt_pkg::OP_WRITE, p, d);
	endtask

	task automatic read_port(pmdt_pkg::byte_t p);
		send_request(pmdt_pkg::OP_READ, p, pmdt_pkg::byte_t'($urandom));
	endtask

	task automatic arm_ms_timer(int unsigned k);
		int unsigned delay_val;
		if ($urandom_range(0, 7) == 0)
			delay_val = $urandom_range(0, 16'hFFFF);
		else
			delay_val = $urandom_range(0, 24);
		// sometimes keep whatever high byte is left over
		if ($urandom_range(0, 4) != 0)
			write_port(hi_port_of(k), pmdt_pkg::byte_t'(delay_val >> 8));
		write_port(lo_port_of(k), pmdt_pkg::byte_t'(delay_val));
	endtask

	task automatic exercise_timers(int unsigned steps);
		int unsigned k;
		repeat (steps) begin
			k = $urandom_range(0, MS_TIMERS - 1);
			if ($urandom_range(0, 1) == 0)
				tick_ms($urandom_range(1, 6));
			else if ($urandom_range(0, 1) == 0)
				read_port(lo_port_of(k));
			else
				read_port(hi_port_of(k));
		end
	endtask

	task automatic send_noise(int unsigned n);
		pmdt_pkg::byte_t p;
		repeat (n) begin
			if ($urandom_range(0, 1) == 0)
				p = pmdt_pkg::byte_t'($urandom_range(22, 32));
			else
				p = pmdt_pkg::byte_t'($urandom);
			send_request(pmdt_pkg::op_t'($urandom_range(0, 3)), p, pmdt_pkg::byte_t'($urandom));
		end
	endtask

	// run up to the last tick before the seconds target, then step across it
	task automatic watch_seconds_timer(pmdt_pkg::byte_t secs);
		write_port(pmdt_pkg::SECONDS_PORT, secs);
		read_port(pmdt_pkg::SECONDS_PORT);
		while (!(sb.ms_of_second == TICKS_PER_SEC - 1
				&& 64'(sb.now_sec) + 1 >= sb.sec_expiry)) begin
			if ($urandom_range(0, 199) == 0)
				read_port(pmdt_pkg::SECONDS_PORT);
			else
				tick_ms(1);
		end
		read_port(pmdt_pkg::SECONDS_PORT);
		tick_ms(1);
		read_port(pmdt_pkg::SECONDS_PORT);
		read_port(pmdt_pkg::SECONDS_PORT);
	endtask

	task automatic run_directed();
		// zero delay at time zero leaves the timer unarmed
		write_port(hi_port_of(0), 8'h00);
		write_port(lo_port_of(0), 8'h00);
		read_port(lo_port_of(0));
		read_port(hi_port_of(0));
		write_port(pmdt_pkg::SECONDS_PORT, 8'h00);
		read_port(pmdt_pkg::SECONDS_PORT);
		read_port(8'h00);
		read_port(pmdt_pkg::byte_t'(pmdt_pkg::FIRST_MS_PORT - 1));
		read_port(pmdt_pkg::byte_t'(pmdt_pkg::SECONDS_PORT + 1));
		read_port(8'hFF);
		write_port(8'hFF, 8'hFF);
		send_request(OP_UNUSED, pmdt_pkg::FIRST_MS_PORT, 8'hFF);
		// longest delay
		write_port(hi_port_of(1), 8'hFF);
		write_port(lo_port_of(1), 8'hFF);
		read_port(hi_port_of(1));
		tick_ms(1);
		write_port(hi_port_of(2), 8'h00);
		write_port(lo_port_of(2), 8'h01);
		read_port(lo_port_of(2));
		tick_ms(1);
		read_port(hi_port_of(2));
		read_port(lo_port_of(2));
		write_port(pmdt_pkg::SECONDS_PORT, 8'hFF);
		read_port(pmdt_pkg::SECONDS_PORT);
		// zero delay once time has started expires at once
		write_port(lo_port_of(0), 8'h00);
		read_port(hi_port_of(0));
	endtask

	task automatic run_random();
		bit seconds_done;
		int unsigned pick;
		seconds_done = 1'b0;
		while (n_counted < RANDOM_ITEMS) begin
			calm = (n_counted >= CALM_AFTER);
			gaps_on = ($urandom_range(0, 3) != 0);
			if (!seconds_done && n_counted >= 40) begin
				seconds_done = 1'b1;
				watch_seconds_timer(8'd1);
			end else begin
				pick = $urandom_range(0, 9);
				case (pick)
					0, 1, 2, 3: begin
						arm_ms_timer($urandom_range(0, MS_TIMERS - 1));
						exercise_timers($urandom_range(2, 8));
					end
					4: begin
						arm_ms_timer($urandom_range(0, MS_TIMERS - 1));
						arm_ms_timer($urandom_range(0, MS_TIMERS - 1));
						exercise_timers($urandom_range(6, 12));
					end
					5: begin
						if ($urandom_range(0, 3) == 0)
							write_port(pmdt_pkg::SECONDS_PORT, pmdt_pkg::byte_t'($urandom));
						else
							write_port(pmdt_pkg::SECONDS_PORT,
								pmdt_pkg::byte_t'($urandom_range(0, 3)));
						read_port(pmdt_pkg::SECONDS_PORT);
					end
					6, 7: send_noise($urandom_range(1, 6));
					8: tick_ms($urandom_range(5, 40));
					default: begin
						for (int unsigned p = pmdt_pkg::FIRST_MS_PORT;
								p <= pmdt_pkg::SECONDS_PORT; p++)
							read_port(pmdt_pkg::byte_t'(p));
					end
				endcase
			end
		end
	endtask

	initial begin
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(0, 2)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		string why;
		if (arst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (!sb.check_result(running, why))
				report_mismatch(why);
		end
	end

	initial begin
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("no request or result moved for %0d cycles", STALL_LIMIT);
		$display("tb_port_mapped_delay_timers NOT OK");
		$finish;
	end

	initial begin
		in_valid <= 1'b0;
		operation <= pmdt_pkg::OP_TICK;
		port <= '0;
		data <= '0;
		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		run_directed();
		run_random();
		in_valid <= 1'b0;
		while (sb.running_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		$display("%0d requests sent, %0d port reads checked, %0d found running, %0d expiries",
			sb.n_requests, sb.n_reads, sb.n_running, sb.n_expiries);
		$display("clock reached %0d ms (%0d s); %0d mismatches",
			sb.now_ms, sb.now_sec, n_mismatches);
		if (n_mismatches == 0)
			$display("tb_port_mapped_delay_timers OK");
		else
			$display("tb_port_mapped_delay_timers NOT OK");
		$finish;
	end

endmodule
